[rtl/core/bhcs_pkg.sv]
// Package: beat types, op and register codes, commutation tables for the Hall block.
`timescale 1ns / 1ps
`default_nettype none
package bhcs_pkg;

	localparam int NUM_W   = 22;
	localparam int QUOT_W  = 22;
	localparam int SPEED_W = 13;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_HALL  = 2'd1;
	localparam logic [1:0] OP_SPEED = 2'd2;

	localparam logic [1:0] REG_POLE_PAIRS = 2'd0;
	localparam logic [1:0] REG_INDEX_POS  = 2'd1;
	localparam logic [1:0] REG_SPEED_NUM  = 2'd2;

	localparam logic [3:0]       POLE_PAIRS_RST = 4'd2;
	localparam logic [2:0]       INDEX_POS_RST  = 3'd1;
	localparam logic [NUM_W-1:0] SPEED_NUM_RST  = 22'd2343750;

	// ceil(2^17 / 3): (q * RECIP3) >> 17 is q / 3 for any 16-bit q
	localparam logic [16:0] RECIP3 = 17'd43691;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCALE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] hall_code;
		logic       direction;
	} in_t;

	typedef struct packed {
		logic [15:0]        drive_pattern;
		logic               revolution_done;
		logic [15:0]        period_average;
		logic [SPEED_W-1:0] speed_value;
		logic               speed_valid;
	} out_t;

	typedef logic [15:0] pat_tbl_t [8];

	localparam pat_tbl_t PATTERN_CW = '{
		16'h0000, 16'h0210, 16'h2004, 16'h0204,
		16'h0801, 16'h0810, 16'h2001, 16'h0000
	};
	localparam pat_tbl_t PATTERN_ACW = '{
		16'h0000, 16'h2001, 16'h0810, 16'h0801,
		16'h0204, 16'h2004, 16'h0210, 16'h0000
	};

endpackage
`default_nettype wire

[rtl/core/bldc_hall_commutation_speed.sv]
// Top level: Hall commutation, revolution period averaging and iterative speed divider.
//
//  channel | direction | handshake         | beat
//  --------+-----------+-------------------+-----------------------------
//  in      | sink      | in_valid/in_stall | in_t: op, hall_code, direction
//  out     | source    | out_valid/out_stall | out_t: pattern, flags, speed
//  cfg     | sink      | cfg_we            | cfg_index, cfg_data
//
// Tick and Hall beats go from idle straight to emit; a speed request runs 22 restoring
// divide steps through one shared subtract/compare unit, one scale multiply, one emit.
// in_stall is high whenever the sequencer is not idle; the result register lets
// a new input beat be taken while the previous result is still stalled.
// Reset clears control and period state and loads register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module bldc_hall_commutation_speed
	import bhcs_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_t                  out_data,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [NUM_W-1:0] cfg_data
);

	localparam int TW = TIMER_WIDTH;
	localparam int RW = ((TW > NUM_W) ? TW : NUM_W) + 1;
	localparam int EW = (TW > 16) ? TW : 16;
	localparam int CW = $clog2(QUOT_W);
	localparam logic [CW-1:0] LAST_STEP = CW'(QUOT_W - 1);

	state_t state_q, state_d;

	logic [3:0]       pole_pairs_q;
	logic [2:0]       index_pos_q;
	logic [NUM_W-1:0] speed_num_q;

	logic [TW-1:0] tick_q;
	logic [3:0]    pole_cnt_q;
	logic [TW-1:0] avg_q;
	logic [15:0]   pattern_q;

	logic [RW-1:0]     rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CW-1:0]     step_q;

	out_t res_q;

	logic          accept;
	logic          emit;
	logic          start_div;
	logic          div_last;
	logic [TW-1:0] tick_d;
	logic [3:0]    pole_cnt_d;
	logic [TW-1:0] avg_d;
	logic [15:0]   pattern_d;
	logic          done_d;
	logic [TW:0]   avg_sum;
	logic [EW-1:0] avg_ext;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] div_avg;
	logic          div_ge;
	logic [15:0]   quot_sat;
	logic [32:0]   scale_prod;

	assign accept = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_data.op == OP_SPEED) ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		start_div = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				start_div = accept && (in_data.op == OP_SPEED);
			end
			ST_EMIT:  emit = !out_valid || !out_stall;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign div_last = (step_q == LAST_STEP);

	// commutation and period update
	assign avg_sum = {1'b0, avg_q} + {1'b0, tick_q};

	always_comb begin
		tick_d     = tick_q;
		pole_cnt_d = pole_cnt_q;
		avg_d      = avg_q;
		pattern_d  = pattern_q;
		done_d     = 1'b0;
		unique case (in_data.op)
			OP_TICK: tick_d = tick_q + TW'(1);
			OP_HALL: begin
				pattern_d = in_data.direction ? PATTERN_CW[in_data.hall_code]
				                              : PATTERN_ACW[in_data.hall_code];
				if (in_data.hall_code == index_pos_q) begin
					if (pole_cnt_q == pole_pairs_q) begin
						tick_d     = '0;
						avg_d      = avg_sum[TW:1];
						pole_cnt_d = 4'd1;
						done_d     = 1'b1;
					end else begin
						pole_cnt_d = pole_cnt_q + 4'd1;
					end
				end
			end
			default: begin
				tick_d = tick_q;
			end
		endcase
	end

	assign avg_ext = EW'(avg_d);

	// shared restoring divide step
	assign div_avg = RW'(avg_q);
	assign rem_sh  = {rem_q[RW-2:0], num_q[NUM_W-1]};
	assign div_ge  = (rem_sh >= div_avg);

	assign quot_sat   = (|quot_q[QUOT_W-1:16]) ? 16'hFFFF : quot_q[15:0];
	assign scale_prod = {1'b0, quot_sat} * {16'd0, RECIP3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pole_pairs_q <= POLE_PAIRS_RST;
			index_pos_q  <= INDEX_POS_RST;
			speed_num_q  <= SPEED_NUM_RST;
			tick_q       <= '0;
			pole_cnt_q   <= 4'd1;
			avg_q        <= '0;
			pattern_q    <= '0;
			out_valid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POLE_PAIRS: pole_pairs_q <= cfg_data[3:0];
					REG_INDEX_POS:  index_pos_q  <= cfg_data[2:0];
					REG_SPEED_NUM:  speed_num_q  <= cfg_data;
					default: begin
						pole_pairs_q <= pole_pairs_q;
					end
				endcase
			end
			if (accept) begin
				tick_q     <= tick_d;
				pole_cnt_q <= pole_cnt_d;
				avg_q      <= avg_d;
				pattern_q  <= pattern_d;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.drive_pattern   <= pattern_d;
			res_q.revolution_done <= done_d;
			res_q.period_average  <= avg_ext[15:0];
			res_q.speed_value     <= '0;
			res_q.speed_valid     <= (in_data.op == OP_SPEED);
		end
		if (start_div) begin
			rem_q  <= '0;
			num_q  <= speed_num_q;
			quot_q <= '0;
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= div_ge ? (rem_sh - div_avg) : rem_sh;
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], div_ge};
			step_q <= step_q + CW'(1);
		end
		if (state_q == ST_SCALE) begin
			res_q.speed_value <= scale_prod[SPEED_W+18:19];
		end
		if (emit) begin
			out_data <= res_q;
		end
	end

endmodule
`default_nettype wire

[tb/bldc_hall_commutation_speed_test.sv]
// Testbench for the Hall commutation and speed block: scoreboard class, drivers, random traffic.
`timescale 1ns / 1ps
module bldc_hall_commutation_speed_test
	import bhcs_pkg::*;
;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         LIMIT_CYCLES = 3000000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         HOLD_CYCLES  = 400;
	localparam logic [2:0] HALL_SEQ [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	class commutation_scoreboard;
		logic [3:0]       pole_pairs;
		logic [2:0]       index_pos;
		logic [NUM_W-1:0] speed_num;
		logic [15:0]      ticks;
		logic [3:0]       pole_cnt;
		logic [15:0]      avg_period;
		logic [15:0]      pattern;
		out_t             pending_results[$];
		int               errors;
		int               results_seen;
		int               captures;
		int               speed_reads;

		function new();
			pole_pairs   = POLE_PAIRS_RST;
			index_pos    = INDEX_POS_RST;
			speed_num    = SPEED_NUM_RST;
			ticks        = '0;
			pole_cnt     = 4'd1;
			avg_period   = '0;
			pattern      = '0;
			errors       = 0;
			results_seen = 0;
			captures     = 0;
			speed_reads  = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [NUM_W-1:0] val);
			case (idx)
				REG_POLE_PAIRS: pole_pairs = val[3:0];
				REG_INDEX_POS:  index_pos = val[2:0];
				REG_SPEED_NUM:  speed_num = val;
				default: ;
			endcase
		endfunction

		function out_t commutate(in_t b);
			out_t        r;
			logic [16:0] sum;
			logic [21:0] quot;
			logic [21:0] scaled;
			r = '0;
			case (b.op)
				OP_TICK: ticks = ticks + 16'd1;
				OP_HALL: begin
					pattern = b.direction ? PATTERN_CW[b.hall_code] : PATTERN_ACW[b.hall_code];
					if (b.hall_code == index_pos) begin
						if (pole_cnt == pole_pairs) begin
							sum = {1'b0, avg_period} + {1'b0, ticks};
							avg_period = sum[16:1];
							ticks = '0;
							pole_cnt = 4'd1;
							r.revolution_done = 1'b1;
						end else begin
							pole_cnt = pole_cnt + 4'd1;
						end
					end
				end
				OP_SPEED: begin
					if (avg_period == 16'd0) begin
						quot = 22'd65535;
					end else begin
						quot = speed_num / avg_period;
						if (quot > 22'd65535)
							quot = 22'd65535;
					end
					scaled = (quot / 22'd3) >> 2;
					r.speed_value = scaled[SPEED_W-1:0];
					r.speed_valid = 1'b1;
				end
				default: ;
			endcase
			r.drive_pattern  = pattern;
			r.period_average = avg_period;
			return r;
		endfunction

		function void note_input(in_t b);
			pending_results.push_back(commutate(b));
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %p", $time, got);
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			if (want.revolution_done)
				captures++;
			if (want.speed_valid)
				speed_reads++;
			compare_field("drive_pattern", 32'(want.drive_pattern), 32'(got.drive_pattern));
			compare_field("revolution_done", 32'(want.revolution_done),
				32'(got.revolution_done));
			compare_field("period_average", 32'(want.period_average),
				32'(got.period_average));
			compare_field("speed_value", 32'(want.speed_value), 32'(got.speed_value));
			compare_field("speed_valid", 32'(want.speed_valid), 32'(got.speed_valid));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_t              in_data;
	logic             out_valid;
	logic             out_stall;
	out_t             out_data;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [NUM_W-1:0] cfg_data;

	commutation_scoreboard sb;
	int burst_left  = 0;
	int items_sent  = 0;
	int rot_pos     = 0;
	bit hold_req    = 1'b0;
	bit hold_issued = 1'b0;

	bldc_hall_commutation_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic in_t beat(logic [1:0] op, logic [2:0] hall, logic dir);
		in_t b;
		b.op        = op;
		b.hall_code = hall;
		b.direction = dir;
		return b;
	endfunction

	task automatic send_beat(in_t b);
		@(negedge clk);
		in_valid = 1'b1;
		in_data  = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(b);
		items_sent++;
	endtask

	task automatic offer(in_t b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		send_beat(b);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [NUM_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic configure(logic [3:0] pp, logic [2:0] ip, logic [NUM_W-1:0] num);
		settle();
		write_reg(REG_POLE_PAIRS, {18'd0, pp});
		write_reg(REG_INDEX_POS, {19'd0, ip});
		write_reg(REG_SPEED_NUM, num);
	endtask

	// mostly clean rotation with tick runs between steps, plus noise and reversals
	task automatic random_phase(int n_items, bit with_hold);
		int   start;
		int   pick;
		int   run;
		logic dir;
		start = items_sent;
		dir = 1'($urandom_range(0, 1));
		while (items_sent - start < n_items) begin
			if (with_hold && !hold_issued && items_sent - start > n_items / 3) begin
				hold_req    = 1'b1;
				hold_issued = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				run = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 400)
					: $urandom_range(0, 5);
				repeat (run)
					offer(beat(OP_TICK, 3'($urandom), 1'($urandom)));
				rot_pos = dir ? (rot_pos + 1) % 6 : (rot_pos + 5) % 6;
				offer(beat(OP_HALL, HALL_SEQ[rot_pos], dir));
			end else if (pick < 70) begin
				offer(beat(OP_SPEED, 3'($urandom), 1'($urandom)));
			end else if (pick < 76) begin
				dir = ~dir;
			end else if (pick < 88) begin
				offer(beat(OP_HALL, 3'($urandom), 1'($urandom)));
			end else if (pick < 93) begin
				offer(beat(OP_UNUSED, 3'($urandom), 1'($urandom)));
			end else begin
				offer(beat(OP_HALL, sb.index_pos, dir));
			end
		end
	endtask

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		int       left;
		int       hold_left;
		rx_mode_t mode;
		left      = 0;
		hold_left = 0;
		mode      = RX_FREE;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
				if (hold_left == 0)
					hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					left = $urandom_range(10, 150);
				end
				left--;
				case (mode)
					RX_FREE:  out_stall = 1'b0;
					RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
					default:  out_stall = ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int h;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;

		// directed: zero average, ignored op, invalid codes, capture, saturation, tables
		offer(beat(OP_SPEED, 3'd0, 1'b0));
		offer(beat(OP_UNUSED, 3'd7, 1'b1));
		repeat (3)
			offer(beat(OP_TICK, 3'd7, 1'b1));
		offer(beat(OP_HALL, 3'd1, 1'b1));
		offer(beat(OP_HALL, 3'd0, 1'b1));
		offer(beat(OP_HALL, 3'd7, 1'b0));
		offer(beat(OP_HALL, 3'd1, 1'b0));
		offer(beat(OP_SPEED, 3'd5, 1'b1));
		for (h = 2; h <= 6; h++)
			offer(beat(OP_HALL, 3'(h), 1'b1));
		for (h = 2; h <= 6; h++)
			offer(beat(OP_HALL, 3'(h), 1'b0));
		offer(beat(OP_UNUSED, 3'd0, 1'b0));
		configure(4'd2, 3'd1, 22'd1);
		offer(beat(OP_SPEED, 3'd2, 1'b0));

		configure(4'd1, 3'($urandom_range(1, 6)), 22'h3FFFFF);
		random_phase(100, 1'b1);
		configure(4'd15, 3'd5, 22'd1);
		random_phase(80, 1'b0);
		configure(4'd3, 3'($urandom_range(0, 7)), 22'($urandom_range(1, 22'h3FFFFF)));
		random_phase(80, 1'b0);
		configure(4'($urandom_range(1, 4)), 3'd0, 22'($urandom_range(1, 22'h3FFFFF)));
		random_phase(70, 1'b0);
		configure(4'd2, 3'd7, SPEED_NUM_RST);
		random_phase(80, 1'b0);
		configure(4'($urandom_range(1, 15)), 3'($urandom), 22'($urandom_range(1, 22'h3FFFFF)));
		random_phase(90, 1'b0);

		// zero pole pairs: counter has to wrap before it matches
		configure(4'd0, 3'd4, 22'($urandom_range(1, 22'h3FFFFF)));
		repeat (18)
			offer(beat(OP_HALL, 3'd4, 1'($urandom)));
		offer(beat(OP_SPEED, 3'd4, 1'b1));

		settle();
		$display("Run: %0d input beats, %0d results checked, %0d revolution captures,",
			items_sent, sb.results_seen, sb.captures);
		$display("     %0d speed reads over several register settings, %0d mismatches",
			sb.speed_reads, sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[sim.f]
rtl/core/bhcs_pkg.sv
rtl/core/bldc_hall_commutation_speed.sv
tb/bldc_hall_commutation_speed_test.sv
